// ===== hdl/t4r_pkg.sv =====
// Shared constants, codes and beat types of the 4bpp tile renderer.
`default_nettype none

package t4r_pkg;

    // Store sizes.
    localparam int TILE_COUNT    = 1024;
    localparam int PALETTE_SLOTS = 80;
    localparam int TILE_WORDS    = TILE_COUNT * 8;
    localparam int TILE_AW       = $clog2(TILE_WORDS);
    localparam int PAL_ENTRIES   = PALETTE_SLOTS * 16;
    localparam int PAL_AW        = $clog2(PAL_ENTRIES);

    // Queue sizes.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Input kind codes.
    localparam logic [1:0] KIND_DRAW      = 2'd0;
    localparam logic [1:0] KIND_LOAD_TILE = 2'd1;
    localparam logic [1:0] KIND_LOAD_PAL  = 2'd2;

    // Operation carried from the front to the back.
    typedef enum logic [1:0] {
        OP_DRAW,
        OP_LOAD_TILE,
        OP_LOAD_PAL
    } op_t;

    // Back-end sequencer states.
    typedef enum logic {
        BK_IDLE,
        BK_DRAW
    } bk_state_t;

    // One queued command.
    typedef struct packed {
        op_t         op;
        logic [9:0]  tile_index;
        logic [2:0]  row;
        logic [3:0]  palette_no;
        logic [6:0]  palette_slot;
        logic [3:0]  color_entry;
        logic        flip_x;
        logic        flip_y;
        logic [31:0] data;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
    } cmd_t;

    // One output pixel beat.
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [15:0] color;
        logic        opaque;
        logic        last;
    } pix_t;

endpackage

`default_nettype wire

// ===== hdl/tile_4bpp_renderer_top.sv =====
// Top level of the 4bpp tile renderer.
//
// Tile rows and palette colors are loaded by input beats and must be written
// before they are drawn from; the stores are not cleared by reset. A draw
// holds the back end and produces 64 pixel beats, column by column, issuing
// one pixel per cycle while the output queue has room. That rate is set by
// the single pixel path, which reads one tile row word per pixel and one
// palette color for each opaque pixel of a valid slot. The first pixel of a
// draw passes the command queue, the sequencer taking the command, the tile
// store read, the palette store read and the output queue write before it
// reaches the result ports. When results are not popped, issue stops once the
// four-entry output queue and the pixels in flight fill it. A small command
// queue lets new beats be taken while a tile is still being drawn. The
// three-bit palette group register is written through cfg_we and cfg_data;
// it must be written only while the block is idle, not enforced by the block.
`default_nettype none

module tile_4bpp_renderer_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_data,
    input  wire         push,
    output logic        full,
    input  wire  [1:0]  kind,
    input  wire  [9:0]  tile_index,
    input  wire  [2:0]  row,
    input  wire  [3:0]  palette_no,
    input  wire  [6:0]  palette_slot,
    input  wire  [3:0]  color_entry,
    input  wire         flip_x,
    input  wire         flip_y,
    input  wire  [31:0] data,
    input  wire  [11:0] dest_x,
    input  wire  [11:0] dest_y,
    input  wire         pop,
    output logic        empty,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [15:0] color,
    output logic        opaque,
    output logic        last
);

    logic                         cmd_valid;
    t4r_pkg::cmd_t                cmd;
    logic                         cmd_pop;
    logic [t4r_pkg::OUTQ_CW-1:0]  outq_count;
    logic                         pix_push;
    t4r_pkg::pix_t                pix_in;
    t4r_pkg::pix_t                pix_out;

    // Front end and command queue.
    t4r_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .tile_index   (tile_index),
        .row          (row),
        .palette_no   (palette_no),
        .palette_slot (palette_slot),
        .color_entry  (color_entry),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .data         (data),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // Stores and pixel pipeline.
    t4r_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .outq_count (outq_count),
        .pix_push   (pix_push),
        .pix        (pix_in)
    );

    // Output queue.
    t4r_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_push (pix_push),
        .pix_in   (pix_in),
        .pop      (pop),
        .empty    (empty),
        .pix_out  (pix_out),
        .count    (outq_count)
    );

    assign pixel_x = pix_out.pixel_x;
    assign pixel_y = pix_out.pixel_y;
    assign color   = pix_out.color;
    assign opaque  = pix_out.opaque;
    assign last    = pix_out.last;

endmodule

`default_nettype wire

// ===== hdl/t4r_front.sv =====
// Front end: accepts input beats, classifies them and queues the commands.
`default_nettype none

module t4r_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire  [1:0]          kind,
    input  wire  [9:0]          tile_index,
    input  wire  [2:0]          row,
    input  wire  [3:0]          palette_no,
    input  wire  [6:0]          palette_slot,
    input  wire  [3:0]          color_entry,
    input  wire                 flip_x,
    input  wire                 flip_y,
    input  wire  [31:0]         data,
    input  wire  [11:0]         dest_x,
    input  wire  [11:0]         dest_y,
    output logic                cmd_valid,
    output t4r_pkg::cmd_t       cmd,
    input  wire                 cmd_pop
);

    t4r_pkg::cmd_t                   q_reg [t4r_pkg::CMDQ_DEPTH];
    logic [t4r_pkg::CMDQ_PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [t4r_pkg::CMDQ_PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [t4r_pkg::CMDQ_CW-1:0]     count_reg, count_next;
    t4r_pkg::cmd_t                   new_cmd;
    logic                            keep;
    logic                            accept;
    logic                            do_push;
    logic                            do_pop;

    // Classify the beat: unused kinds and loads into missing slots are dropped.
    always_comb
    begin
        new_cmd.tile_index   = tile_index;
        new_cmd.row          = row;
        new_cmd.palette_no   = palette_no;
        new_cmd.palette_slot = palette_slot;
        new_cmd.color_entry  = color_entry;
        new_cmd.flip_x       = flip_x;
        new_cmd.flip_y       = flip_y;
        new_cmd.data         = data;
        new_cmd.dest_x       = dest_x;
        new_cmd.dest_y       = dest_y;
        new_cmd.op           = t4r_pkg::OP_DRAW;
        keep                 = 1'b0;
        case (kind)
            t4r_pkg::KIND_DRAW:
            begin
                new_cmd.op = t4r_pkg::OP_DRAW;
                keep       = 1'b1;
            end
            t4r_pkg::KIND_LOAD_TILE:
            begin
                new_cmd.op = t4r_pkg::OP_LOAD_TILE;
                keep       = 32'(tile_index) < 32'(t4r_pkg::TILE_COUNT);
            end
            t4r_pkg::KIND_LOAD_PAL:
            begin
                new_cmd.op = t4r_pkg::OP_LOAD_PAL;
                keep       = 32'(palette_slot) < 32'(t4r_pkg::PALETTE_SLOTS);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Queue control.
    always_comb
    begin
        full        = count_reg == t4r_pkg::CMDQ_CW'(t4r_pkg::CMDQ_DEPTH);
        cmd_valid   = count_reg != '0;
        cmd         = q_reg[rd_ptr_reg];
        accept      = push && !full;
        do_push     = accept && keep;
        do_pop      = cmd_pop && cmd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == t4r_pkg::CMDQ_PW'(t4r_pkg::CMDQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == t4r_pkg::CMDQ_PW'(t4r_pkg::CMDQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointer and fill registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/t4r_back.sv =====
// Back end: tile and palette stores, load execution and the pixel pipeline.
`default_nettype none

module t4r_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire  [2:0]                   cfg_data,
    input  wire                          cmd_valid,
    input  t4r_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    input  wire  [t4r_pkg::OUTQ_CW-1:0]  outq_count,
    output logic                         pix_push,
    output t4r_pkg::pix_t                pix
);

    // Stores, undefined until loaded.
    logic [31:0]                 tile_mem [t4r_pkg::TILE_WORDS];
    logic [15:0]                 pal_mem  [t4r_pkg::PAL_ENTRIES];

    t4r_pkg::bk_state_t          state_reg, state_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic [2:0]                  tod_reg;
    t4r_pkg::cmd_t               drw_reg;
    logic [6:0]                  slot_reg;
    logic                        slot_ok_reg;

    logic                        s1_valid_reg;
    logic [2:0]                  s1_sx_reg;
    logic [11:0]                 s1_x_reg, s1_y_reg;
    logic                        s1_last_reg;
    logic [31:0]                 tile_rdata_reg;

    logic                        s2_valid_reg;
    logic                        s2_opaque_reg;
    logic                        s2_en_reg;
    logic [11:0]                 s2_x_reg, s2_y_reg;
    logic                        s2_last_reg;
    logic [15:0]                 pal_rdata_reg;

    logic                        tile_we, pal_we, draw_start, issue, credit_ok;
    logic [t4r_pkg::OUTQ_CW:0]   pending;
    logic [2:0]                  col, prow, sx, sy;
    logic [3:0]                  nibble;
    logic [6:0]                  new_slot;

    assign col      = cnt_reg[5:3];
    assign prow     = cnt_reg[2:0];
    assign sx       = drw_reg.flip_x ? ~col : col;
    assign sy       = drw_reg.flip_y ? ~prow : prow;
    assign nibble   = tile_rdata_reg[{s1_sx_reg, 2'b00} +: 4];
    assign new_slot = {tod_reg, cmd.palette_no};

    // Issue only when every pixel in flight still has a queue place.
    assign pending   = (t4r_pkg::OUTQ_CW + 1)'(outq_count)
                     + (t4r_pkg::OUTQ_CW + 1)'(s1_valid_reg)
                     + (t4r_pkg::OUTQ_CW + 1)'(s2_valid_reg);
    assign credit_ok = pending < (t4r_pkg::OUTQ_CW + 1)'(t4r_pkg::OUTQ_DEPTH);

    // Sequencer: one command per cycle when idle, one pixel per cycle when drawing and the queue has room.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        tile_we    = 1'b0;
        pal_we     = 1'b0;
        draw_start = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            t4r_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        t4r_pkg::OP_LOAD_TILE: tile_we = 1'b1;
                        t4r_pkg::OP_LOAD_PAL:  pal_we  = 1'b1;
                        t4r_pkg::OP_DRAW:
                        begin
                            draw_start = 1'b1;
                            cnt_next   = '0;
                            state_next = t4r_pkg::BK_DRAW;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            t4r_pkg::BK_DRAW:
            begin
                if (credit_ok)
                begin
                    issue    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (&cnt_reg)
                    begin
                        state_next = t4r_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = t4r_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= t4r_pkg::BK_IDLE;
            cnt_reg      <= '0;
            tod_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_we)
            begin
                tod_reg <= cfg_data;
            end
        end
    end

    // Draw parameters, held for the whole tile.
    always_ff @(posedge clk)
    begin
        if (draw_start)
        begin
            drw_reg     <= cmd;
            slot_reg    <= new_slot;
            slot_ok_reg <= 32'(new_slot) < 32'(t4r_pkg::PALETTE_SLOTS);
        end
    end

    // Tile store: row load or row read for the pixel being issued.
    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[t4r_pkg::TILE_AW'({cmd.tile_index, cmd.row})] <= cmd.data;
        end
        if (issue)
        begin
            tile_rdata_reg <= tile_mem[t4r_pkg::TILE_AW'({drw_reg.tile_index, sy})];
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_sx_reg   <= sx;
            s1_x_reg    <= drw_reg.dest_x + 12'(col);
            s1_y_reg    <= drw_reg.dest_y + 12'(prow);
            s1_last_reg <= &cnt_reg;
        end
    end

    // Palette store: colour load or colour lookup for stage one.
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[t4r_pkg::PAL_AW'({cmd.palette_slot, cmd.color_entry})] <= cmd.data[15:0];
        end
        if (s1_valid_reg && slot_ok_reg && (nibble != 4'd0))
        begin
            pal_rdata_reg <= pal_mem[t4r_pkg::PAL_AW'({slot_reg, nibble})];
        end
    end

    // Stage two payload.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_opaque_reg <= nibble != 4'd0;
            s2_en_reg     <= slot_ok_reg && (nibble != 4'd0);
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Finished pixel beat toward the output queue.
    always_comb
    begin
        pix_push    = s2_valid_reg;
        pix.pixel_x = s2_x_reg;
        pix.pixel_y = s2_y_reg;
        pix.color   = s2_en_reg ? pal_rdata_reg : 16'd0;
        pix.opaque  = s2_opaque_reg;
        pix.last    = s2_last_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/t4r_outq.sv =====
// Output queue holding finished pixel beats until they are popped.
`default_nettype none

module t4r_outq (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          pix_push,
    input  t4r_pkg::pix_t                pix_in,
    input  wire                          pop,
    output logic                         empty,
    output t4r_pkg::pix_t                pix_out,
    output logic [t4r_pkg::OUTQ_CW-1:0]  count
);

    t4r_pkg::pix_t                   q_reg [t4r_pkg::OUTQ_DEPTH];
    logic [t4r_pkg::OUTQ_PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [t4r_pkg::OUTQ_PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [t4r_pkg::OUTQ_CW-1:0]     count_reg, count_next;
    logic                            do_pop;

    // The producer never pushes without a free place, so no full check here.
    always_comb
    begin
        empty       = count_reg == '0;
        count       = count_reg;
        pix_out     = q_reg[rd_ptr_reg];
        do_pop      = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (pix_push)
        begin
            wr_ptr_next = (wr_ptr_reg == t4r_pkg::OUTQ_PW'(t4r_pkg::OUTQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == t4r_pkg::OUTQ_PW'(t4r_pkg::OUTQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (pix_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !pix_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointer and fill registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (pix_push)
        begin
            q_reg[wr_ptr_reg] <= pix_in;
        end
    end

endmodule

`default_nettype wire
